// File: rtl/sai_pkg.sv
// ----------------------------------------------------------------------------
// Sorted array package
// Shared sizes, command and status codes, and the item types of the
// sorted array insert/remove block.
// ----------------------------------------------------------------------------
package sai_pkg;

  // Capacity of the store and the widths that follow from it.
  localparam int DEPTH  = 16;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int DATA_W = 32;

  // Command codes of an input item. The reserved code acts as a read.
  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_READ   = 2'd2,
    CMD_RSVD   = 2'd3
  } cmd_e;

  // Status codes of a result item.
  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2,
    ST_RSVD  = 2'd3
  } status_e;

  // Per-cycle operation broadcast to every cell of the row.
  typedef enum logic [2:0] {
    OP_NONE,
    OP_INS_SORT,
    OP_INS_APPEND,
    OP_REM_SHIFT,
    OP_REM_SWAP
  } op_e;

  // Control group sent from the top level to each cell.
  typedef struct packed {
    op_e                      op;
    logic signed [DATA_W-1:0] value;
    logic [IDX_W-1:0]         index;
    logic [CNT_W-1:0]         count;
  } cell_ctrl_t;

  // Input item.
  typedef struct packed {
    cmd_e                     cmd;
    logic signed [DATA_W-1:0] value;
    logic [IDX_W-1:0]         index;
  } sai_in_t;

  // Result item.
  typedef struct packed {
    status_e                  status;
    logic [IDX_W-1:0]         position;
    logic signed [DATA_W-1:0] data;
    logic [CNT_W-1:0]         count;
  } sai_out_t;

endpackage

// File: rtl/sai_cell.sv
// ----------------------------------------------------------------------------
// Sorted array cell
// Holds one entry of the store. On each operation it keeps its entry, takes
// the new value, takes the entry of a neighbor, or takes the last stored entry,
// as the broadcast control and its own slot number decide.
// ----------------------------------------------------------------------------
module sai_cell (
  input  logic                               clk_i,
  input  logic [sai_pkg::IDX_W-1:0]          slot_i,
  input  sai_pkg::cell_ctrl_t                ctrl_i,
  input  logic                               left_gt_i,
  input  logic                               right_gt_i,
  input  logic signed [sai_pkg::DATA_W-1:0]  left_entry_i,
  input  logic signed [sai_pkg::DATA_W-1:0]  right_entry_i,
  input  logic signed [sai_pkg::DATA_W-1:0]  last_entry_i,
  output logic                               gt_o,
  output logic signed [sai_pkg::DATA_W-1:0]  entry_o
);
  import sai_pkg::*;

  logic signed [DATA_W-1:0] entry_q, entry_d;
  logic [CNT_W-1:0]         slot_w;
  logic                     occupied;
  logic                     at_end;
  logic                     at_last;

  assign slot_w   = CNT_W'(slot_i);
  assign occupied = slot_w < ctrl_i.count;
  assign at_end   = slot_w == ctrl_i.count;
  assign at_last  = (slot_w + CNT_W'(1)) == ctrl_i.count;

  // This entry is larger than the value being inserted, and so is every
  // stored entry above it up to the last one. Only that unbroken run at the
  // top of the store moves up, even when the entries are not in order.
  assign gt_o    = occupied && (entry_q > ctrl_i.value) && (at_last || right_gt_i);
  assign entry_o = entry_q;

  // Next entry of the cell.
  always_comb begin
    entry_d = entry_q;
    unique case (ctrl_i.op)
      OP_INS_SORT: begin
        if (left_gt_i) begin
          entry_d = left_entry_i;
        end else if (gt_o || at_end) begin
          entry_d = ctrl_i.value;
        end
      end
      OP_INS_APPEND: begin
        if (at_end) begin
          entry_d = ctrl_i.value;
        end
      end
      OP_REM_SHIFT: begin
        if ((slot_i >= ctrl_i.index) && ((slot_w + CNT_W'(1)) < ctrl_i.count)) begin
          entry_d = right_entry_i;
        end
      end
      OP_REM_SWAP: begin
        if (slot_i == ctrl_i.index) begin
          entry_d = last_entry_i;
        end
      end
      default: begin
        entry_d = entry_q;
      end
    endcase
  end

  // Entry storage: payload only, no reset.
  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

// File: rtl/sorted_array_insert_remove.sv
// ----------------------------------------------------------------------------
// Sorted array insert/remove
// Fixed-capacity store of signed values kept in a row of cells, with sorted
// insert and shifting remove, or append and swap-remove, plus indexed read.
// ----------------------------------------------------------------------------
// Timing: the result of an item shows on result_o with done_o in the cycle
//   after start is taken.
// Throughput: one item per cycle once busy drops after reset; every cell
//   compares and shifts in the same cycle, so the row of cells sets the pace.
// Reset: the count clears, ordered mode is set, busy is high during reset;
//   entries hold no defined value until written. Results cannot be stalled.
module sorted_array_insert_remove (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  sai_pkg::sai_in_t  item_i,
  input  logic              cfg_we_i,
  input  logic              cfg_wdata_i,
  output logic              done_o,
  output sai_pkg::sai_out_t result_o
);
  import sai_pkg::*;

  logic                     busy_q;
  logic                     ordered_q;
  logic [CNT_W-1:0]         count_q, count_d;
  logic                     done_q;
  sai_out_t                 result_q, result_d;
  logic                     accept;
  cell_ctrl_t               ctrl;
  logic [DEPTH-1:0]         gt;
  logic signed [DATA_W-1:0] entry [DEPTH];
  logic signed [DATA_W-1:0] rd_entry;
  logic signed [DATA_W-1:0] last_entry;
  logic [CNT_W-1:0]         last_idx;
  logic [CNT_W-1:0]         sort_slot;
  logic                     full;
  logic                     in_range;

  assign accept   = start && !busy_q;
  assign full     = count_q == CNT_W'(DEPTH);
  assign in_range = CNT_W'(item_i.index) < count_q;
  assign last_idx = count_q - CNT_W'(1);

  // Selected entries: the one at the given index and the last stored one.
  assign rd_entry   = entry[item_i.index];
  assign last_entry = entry[last_idx[IDX_W-1:0]];

  // Sorted insert slot: the run of larger entries at the top of the store
  // moves up one slot and the value lands just below it.
  assign sort_slot = count_q - CNT_W'($countones(gt));

  // Operation broadcast to the cells.
  always_comb begin
    ctrl.op    = OP_NONE;
    ctrl.value = item_i.value;
    ctrl.index = item_i.index;
    ctrl.count = count_q;
    if (accept) begin
      unique case (item_i.cmd)
        CMD_INSERT: begin
          if (!full) begin
            ctrl.op = ordered_q ? OP_INS_SORT : OP_INS_APPEND;
          end
        end
        CMD_REMOVE: begin
          if (in_range) begin
            ctrl.op = ordered_q ? OP_REM_SHIFT : OP_REM_SWAP;
          end
        end
        CMD_READ, CMD_RSVD: begin
          ctrl.op = OP_NONE;
        end
      endcase
    end
  end

  // Row of cells, each linked to its neighbors.
  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic                     left_gt;
    logic                     right_gt;
    logic signed [DATA_W-1:0] left_entry;
    logic signed [DATA_W-1:0] right_entry;

    if (k == 0) begin : g_first
      assign left_gt    = 1'b0;
      assign left_entry = '0;
    end else begin : g_mid
      assign left_gt    = gt[k-1];
      assign left_entry = entry[k-1];
    end

    if (k == DEPTH - 1) begin : g_last
      assign right_gt    = 1'b0;
      assign right_entry = '0;
    end else begin : g_inner
      assign right_gt    = gt[k+1];
      assign right_entry = entry[k+1];
    end

    sai_cell u_cell (
      .clk_i         (clk_i),
      .slot_i        (IDX_W'(k)),
      .ctrl_i        (ctrl),
      .left_gt_i     (left_gt),
      .right_gt_i    (right_gt),
      .left_entry_i  (left_entry),
      .right_entry_i (right_entry),
      .last_entry_i  (last_entry),
      .gt_o          (gt[k]),
      .entry_o       (entry[k])
    );
  end

  // Result item and next count.
  always_comb begin
    count_d           = count_q;
    result_d.status   = ST_DONE;
    result_d.position = item_i.index;
    result_d.data     = '0;
    result_d.count    = count_q;
    unique case (item_i.cmd)
      CMD_INSERT: begin
        if (full) begin
          result_d.status   = ST_FULL;
          result_d.position = '0;
        end else begin
          count_d           = count_q + CNT_W'(1);
          result_d.position = ordered_q ? sort_slot[IDX_W-1:0] : count_q[IDX_W-1:0];
          result_d.data     = item_i.value;
          result_d.count    = count_d;
        end
      end
      CMD_REMOVE: begin
        if (!in_range) begin
          result_d.status = ST_RANGE;
        end else begin
          count_d        = count_q - CNT_W'(1);
          result_d.data  = rd_entry;
          result_d.count = count_d;
        end
      end
      CMD_READ, CMD_RSVD: begin
        if (!in_range) begin
          result_d.status = ST_RANGE;
        end else begin
          result_d.data = rd_entry;
        end
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b1;
      ordered_q <= 1'b1;
      count_q   <= '0;
      done_q    <= 1'b0;
    end else begin
      busy_q <= 1'b0;
      done_q <= accept;
      if (cfg_we_i) begin
        ordered_q <= cfg_wdata_i;
      end
      if (accept) begin
        count_q <= count_d;
      end
    end
  end

  // Result register: payload only.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      result_q <= result_d;
    end
  end

  assign busy     = busy_q;
  assign done_o   = done_q;
  assign result_o = result_q;

endmodule

// File: rtl/sai_checker.sv
// ----------------------------------------------------------------------------
// Sorted array checker
// Port-level assertions on the sorted array block, attached by bind.
// ----------------------------------------------------------------------------
module sai_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start,
  input logic              busy,
  input logic              done_o,
  input sai_pkg::sai_out_t result_o
);
  import sai_pkg::*;

  // Every accepted item yields one result in the next cycle.
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> done_o)
    else $error("no result after an accepted item");

  // No result appears without an accepted item.
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(start && !busy) |=> !done_o)
    else $error("result without an accepted item");

  // A full rejection reports a full store.
  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (result_o.status == ST_FULL)) |-> (result_o.count == CNT_W'(DEPTH)))
    else $error("full status with a store that is not full");

  // An index rejection names an index at or beyond the count.
  a_range_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (result_o.status == ST_RANGE))
      |-> (CNT_W'(result_o.position) >= result_o.count))
    else $error("index rejected although below the count");

  // The count never exceeds the capacity.
  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (result_o.count <= CNT_W'(DEPTH)))
    else $error("count beyond capacity");

endmodule

bind sorted_array_insert_remove sai_checker u_sai_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start    (start),
  .busy     (busy),
  .done_o   (done_o),
  .result_o (result_o)
);
